/* rtl/atm_pkg.sv */
// ----------------------------------------------------------------------------
// atm_pkg
// shared types and constants of the allocation tracking monitor
// ----------------------------------------------------------------------------
package atm_pkg;

  localparam int RecDepth  = 1024;
  localparam int SiteDepth = 128;
  localparam int ModCount  = 64;
  localparam int RecIdxW   = $clog2(RecDepth);
  localparam int RecCntW   = $clog2(RecDepth + 1);
  localparam int SiteIdxW  = $clog2(SiteDepth);
  localparam int SiteCntW  = $clog2(SiteDepth + 1);
  localparam int ModIdxW   = $clog2(ModCount);
  localparam int QDepth    = 2;

  localparam logic [47:0] ByteMax = 48'hFFFF_FFFF_FFFF;
  localparam logic [31:0] CntMax  = 32'hFFFF_FFFF;

  localparam logic [1:0] OpAlloc = 2'd0;
  localparam logic [1:0] OpFree  = 2'd1;

  typedef enum logic [1:0] {
    CMD_ALLOC = 2'd0,
    CMD_FREE  = 2'd1,
    CMD_READ  = 2'd2
  } cmd_t;

  typedef struct packed {
    cmd_t        cmd;
    logic [47:0] address;
    logic [31:0] size;
    logic [47:0] callsite;
    logic [5:0]  module_id;
    logic [6:0]  read_index;
  } work_t;

  typedef struct packed {
    logic [10:0] live_records;
    logic [47:0] current_bytes;
    logic [47:0] byte_peak;
    logic [47:0] byte_sum;
    logic [31:0] total_count;
    logic [31:0] hist_count;
    logic [47:0] site_address;
    logic [31:0] site_allocs;
    logic [47:0] site_bytes;
    logic [47:0] module_current;
    logic [47:0] module_peak;
    logic [31:0] module_allocs;
  } result_t;

  function automatic logic [2:0] size_bucket(input logic [31:0] s);
    if (s <= 32'd64) return 3'd0;
    if (s <= 32'd256) return 3'd1;
    if (s <= 32'd1024) return 3'd2;
    if (s <= 32'd4096) return 3'd3;
    return 3'd4;
  endfunction

  function automatic logic [47:0] sat_add48(input logic [47:0] a, input logic [47:0] b);
    logic [48:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[48] || (s[47:0] == ByteMax) ? ByteMax : s[47:0];
  endfunction

  function automatic logic [31:0] sat_inc32(input logic [31:0] a);
    return (a == CntMax) ? CntMax : a + 32'd1;
  endfunction

endpackage

/* rtl/atm_if.sv */
// ----------------------------------------------------------------------------
// atm_if
// valid/ready channel carrying one payload
// ----------------------------------------------------------------------------
interface atm_if #(parameter type payload_t = logic) ();
  logic     valid;
  logic     ready;
  payload_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

/* rtl/atm_front.sv */
// ----------------------------------------------------------------------------
// atm_front
// accepts input transactions, classifies them and queues work commands
// ----------------------------------------------------------------------------
module atm_front (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              enable,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic [1:0]        op,
  input  logic [47:0]       address,
  input  logic [31:0]       size,
  input  logic [47:0]       callsite,
  input  logic [5:0]        module_id,
  input  logic [6:0]        read_index,
  output logic              q_valid,
  input  logic              q_pop,
  output atm_pkg::work_t    q_data
);
  import atm_pkg::*;

  work_t       q_mem [QDepth];
  logic        wr_ptr_r, rd_ptr_r;
  logic [1:0]  cnt_r;
  work_t       w;
  logic        push;

  // classification: disabled, null address or an op other than alloc or free becomes a plain read
  always_comb begin
    w.address    = address;
    w.size       = size;
    w.callsite   = callsite;
    w.module_id  = module_id;
    w.read_index = read_index;
    w.cmd        = CMD_READ;
    if (enable && address != '0) begin
      if (op == OpAlloc) w.cmd = CMD_ALLOC;
      else if (op == OpFree) w.cmd = CMD_FREE;
    end
  end

  assign in_ready = (cnt_r != 2'(QDepth));
  assign push     = in_valid && in_ready;
  assign q_valid  = (cnt_r != 2'd0);
  assign q_data   = q_mem[rd_ptr_r];

  // command queue
  always_ff @(posedge clk) begin
    if (push) q_mem[wr_ptr_r] <= w;
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      cnt_r    <= 2'd0;
    end else begin
      if (push) wr_ptr_r <= ~wr_ptr_r;
      if (q_pop) rd_ptr_r <= ~rd_ptr_r;
      cnt_r <= cnt_r + 2'(push) - 2'(q_pop);
    end
  end
endmodule

/* rtl/atm_back.sv */
// ----------------------------------------------------------------------------
// atm_back
// executes queued commands: record table scan, site search, counters
// ----------------------------------------------------------------------------
module atm_back (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              q_valid,
  output logic              q_pop,
  input  atm_pkg::work_t    q_data,
  output logic              out_valid,
  input  logic              out_ready,
  output atm_pkg::result_t  out_data
);
  import atm_pkg::*;

  typedef enum logic [9:0] {
    S_IDLE   = 10'b0000000001,
    S_SITE   = 10'b0000000010,
    S_SITEWR = 10'b0000000100,
    S_MOD    = 10'b0000001000,
    S_FSCAN  = 10'b0000010000,
    S_FHIT   = 10'b0000100000,
    S_SHIFT  = 10'b0001000000,
    S_SHWR   = 10'b0010000000,
    S_RD     = 10'b0100000000,
    S_OUT    = 10'b1000000000
  } state_t;

  state_t state_r;
  work_t  cur_r;

  // record memory
  logic [47:0] rec_addr_mem [RecDepth];
  logic [31:0] rec_size_mem [RecDepth];
  logic [5:0]  rec_mod_mem  [RecDepth];
  logic [47:0] rd_addr_r;
  logic [31:0] rd_size_r;
  logic [5:0]  rd_mod_r;
  logic [RecIdxW-1:0] rec_raddr;
  logic        rec_we;
  logic [RecIdxW-1:0] rec_waddr;
  logic [47:0] rec_waddr_d;
  logic [31:0] rec_wsize;
  logic [5:0]  rec_wmod;

  // site memory
  logic [47:0] site_key_mem [SiteDepth];
  logic [31:0] site_cnt_mem [SiteDepth];
  logic [47:0] site_byt_mem [SiteDepth];
  logic [47:0] sk_r;
  logic [31:0] sc_r;
  logic [47:0] sb_r;
  logic [SiteIdxW-1:0] site_raddr;

  // module memory
  logic [47:0] mod_now_mem [ModCount];
  logic [47:0] mod_hi_mem  [ModCount];
  logic [31:0] mod_cnt_mem [ModCount];
  logic [ModCount-1:0] mod_vld_r;
  logic [47:0] mn_r, mh_r;
  logic [31:0] mc_r;
  logic [ModIdxW-1:0] mod_raddr;

  logic [RecCntW-1:0]  rec_fill_r;
  logic [SiteCntW-1:0] site_fill_r;
  logic [SiteDepth-1:0] site_vld_r;
  logic [47:0] now_r, peak_r, tot_r;
  logic [31:0] cnt_r;
  logic [31:0] hist_r [5];

  logic [RecCntW-1:0] idx_r;
  logic        rd_pend_r;
  logic [31:0] fsize_r;
  logic [5:0]  fmod_r;
  logic        mod_pend_r;
  result_t     res_r;
  logic        ovalid_r;

  logic [47:0] now_add;
  logic [2:0]  bkt;
  logic [ModIdxW-1:0] ri_mod;
  logic [SiteIdxW-1:0] ri_site;

  assign now_add   = sat_add48(now_r, {16'd0, cur_r.size});
  assign bkt       = size_bucket(cur_r.size);
  assign ri_mod    = cur_r.read_index[ModIdxW-1:0];
  assign ri_site   = cur_r.read_index[SiteIdxW-1:0];
  assign out_valid = ovalid_r;
  assign out_data  = res_r;
  assign q_pop     = (state_r == S_IDLE) && q_valid && !ovalid_r;

  // memory read address selection
  always_comb begin
    rec_raddr  = idx_r[RecIdxW-1:0];
    site_raddr = (state_r == S_RD) ? ri_site : idx_r[SiteIdxW-1:0];
    mod_raddr  = (state_r == S_RD) ? ri_mod
               : (state_r == S_FHIT) ? rd_mod_r : cur_r.module_id;
  end

  // record write port
  always_comb begin
    rec_we      = 1'b0;
    rec_waddr   = idx_r[RecIdxW-1:0];
    rec_waddr_d = rd_addr_r;
    rec_wsize   = rd_size_r;
    rec_wmod    = rd_mod_r;
    if (state_r == S_SITE && idx_r == '0 && rec_fill_r < RecCntW'(RecDepth)
        && rd_pend_r) begin
      rec_we      = 1'b1;
      rec_waddr   = rec_fill_r[RecIdxW-1:0];
      rec_waddr_d = cur_r.address;
      rec_wsize   = cur_r.size;
      rec_wmod    = cur_r.module_id;
    end else if (state_r == S_SHWR) begin
      rec_we    = 1'b1;
      rec_waddr = RecIdxW'(idx_r - 1'b1);
    end
  end

  // memories
  always_ff @(posedge clk) begin
    if (rec_we) begin
      rec_addr_mem[rec_waddr] <= rec_waddr_d;
      rec_size_mem[rec_waddr] <= rec_wsize;
      rec_mod_mem[rec_waddr]  <= rec_wmod;
    end
    rd_addr_r <= rec_addr_mem[rec_raddr];
    rd_size_r <= rec_size_mem[rec_raddr];
    rd_mod_r  <= rec_mod_mem[rec_raddr];
    sk_r <= site_key_mem[site_raddr];
    sc_r <= site_cnt_mem[site_raddr];
    sb_r <= site_byt_mem[site_raddr];
    mn_r <= mod_now_mem[mod_raddr];
    mh_r <= mod_hi_mem[mod_raddr];
    mc_r <= mod_cnt_mem[mod_raddr];
    if (state_r == S_SITEWR) begin
      if (idx_r[SiteIdxW-1:0] < site_fill_r && sk_r == cur_r.callsite
          && site_vld_r[idx_r[SiteIdxW-1:0]]) begin
        site_cnt_mem[idx_r[SiteIdxW-1:0]] <= sat_inc32(sc_r);
        site_byt_mem[idx_r[SiteIdxW-1:0]] <= sat_add48(sb_r, {16'd0, cur_r.size});
      end else if (32'(idx_r) == 32'(site_fill_r) && site_fill_r < SiteCntW'(SiteDepth)) begin
        site_key_mem[idx_r[SiteIdxW-1:0]] <= cur_r.callsite;
        site_cnt_mem[idx_r[SiteIdxW-1:0]] <= 32'd1;
        site_byt_mem[idx_r[SiteIdxW-1:0]] <= sat_add48(48'd0, {16'd0, cur_r.size});
      end
    end
    if (state_r == S_MOD && mod_pend_r) begin
      logic [47:0] n0, n1;
      n0 = mod_vld_r[cur_r.module_id] ? mn_r : 48'd0;
      n1 = sat_add48(n0, {16'd0, cur_r.size});
      mod_now_mem[cur_r.module_id] <= n1;
      mod_cnt_mem[cur_r.module_id] <=
        sat_inc32(mod_vld_r[cur_r.module_id] ? mc_r : 32'd0);
      mod_hi_mem[cur_r.module_id] <=
        (mod_vld_r[cur_r.module_id] && mh_r >= n1) ? mh_r : n1;
    end
    if (state_r == S_SHIFT && mod_pend_r && mod_vld_r[fmod_r]
        && mn_r >= {16'd0, fsize_r}) begin
      mod_now_mem[fmod_r] <= mn_r - {16'd0, fsize_r};
    end
  end

  // control sequencer
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      ovalid_r    <= 1'b0;
      rec_fill_r  <= '0;
      site_fill_r <= '0;
      site_vld_r  <= '0;
      mod_vld_r   <= '0;
      now_r <= '0; peak_r <= '0; tot_r <= '0; cnt_r <= '0;
      for (int k = 0; k < 5; k++) hist_r[k] <= '0;
      idx_r <= '0; rd_pend_r <= 1'b0; mod_pend_r <= 1'b0;
    end else begin
      if (ovalid_r && out_ready) ovalid_r <= 1'b0;
      case (state_r)
        S_IDLE: begin
          if (q_pop) begin
            cur_r <= q_data;
            idx_r <= '0;
            rd_pend_r <= 1'b1;
            case (q_data.cmd)
              CMD_ALLOC: state_r <= S_SITE;
              CMD_FREE:  state_r <= S_FSCAN;
              default:   state_r <= S_RD;
            endcase
          end
        end
        // alloc: globals and record at first step, then site search
        S_SITE: begin
          if (rd_pend_r) begin
            rd_pend_r <= 1'b0;
            if (rec_fill_r < RecCntW'(RecDepth)) rec_fill_r <= rec_fill_r + 1'b1;
            tot_r  <= sat_add48(tot_r, {16'd0, cur_r.size});
            now_r  <= now_add;
            if (now_add > peak_r) peak_r <= now_add;
            cnt_r  <= sat_inc32(cnt_r);
            hist_r[bkt] <= sat_inc32(hist_r[bkt]);
          end
          state_r <= S_SITEWR;
        end
        S_SITEWR: begin
          if (idx_r[SiteIdxW-1:0] < site_fill_r && sk_r == cur_r.callsite
              && site_vld_r[idx_r[SiteIdxW-1:0]]) begin
            state_r <= S_MOD;
            mod_pend_r <= 1'b1;
          end else if (32'(idx_r) >= 32'(site_fill_r)) begin
            if (site_fill_r < SiteCntW'(SiteDepth)) begin
              site_vld_r[idx_r[SiteIdxW-1:0]] <= 1'b1;
              site_fill_r <= site_fill_r + 1'b1;
            end
            state_r <= S_MOD;
            mod_pend_r <= 1'b1;
          end else begin
            idx_r   <= idx_r + 1'b1;
            state_r <= S_SITE;
          end
        end
        S_MOD: begin
          if (mod_pend_r) begin
            mod_pend_r <= 1'b0;
            mod_vld_r[cur_r.module_id] <= 1'b1;
          end
          state_r <= S_RD;
        end
        // free: one record read per step
        S_FSCAN: begin
          rd_pend_r <= 1'b0;
          if (idx_r >= rec_fill_r) state_r <= S_RD;
          else if (!rd_pend_r) begin
            if (rd_addr_r == cur_r.address) state_r <= S_FHIT;
            else begin
              idx_r <= idx_r + 1'b1;
              rd_pend_r <= 1'b1;
            end
          end
        end
        S_FHIT: begin
          fsize_r <= rd_size_r;
          fmod_r  <= rd_mod_r;
          now_r   <= (now_r >= {16'd0, rd_size_r}) ? now_r - {16'd0, rd_size_r} : '0;
          mod_pend_r <= 1'b1;
          idx_r   <= idx_r + 1'b1;
          state_r <= S_SHIFT;
        end
        // compact the table: each pass through S_SHIFT and S_SHWR moves one entry down
        S_SHIFT: begin
          mod_pend_r <= 1'b0;
          if (idx_r >= rec_fill_r) begin
            rec_fill_r <= rec_fill_r - 1'b1;
            state_r    <= S_RD;
          end else state_r <= S_SHWR;
        end
        S_SHWR: begin
          idx_r   <= idx_r + 1'b1;
          state_r <= S_SHIFT;
        end
        S_RD: state_r <= S_OUT;
        S_OUT: begin
          res_r.live_records  <= rec_fill_r;
          res_r.current_bytes <= now_r;
          res_r.byte_peak     <= peak_r;
          res_r.byte_sum      <= tot_r;
          res_r.total_count   <= cnt_r;
          res_r.hist_count    <= (cur_r.read_index < 7'd5) ? hist_r[cur_r.read_index[2:0]] : '0;
          if (32'(cur_r.read_index) < 32'(site_fill_r)) begin
            res_r.site_address <= sk_r;
            res_r.site_allocs  <= sc_r;
            res_r.site_bytes   <= sb_r;
          end else begin
            res_r.site_address <= '0;
            res_r.site_allocs  <= '0;
            res_r.site_bytes   <= '0;
          end
          if (32'(cur_r.read_index) < ModCount && mod_vld_r[ri_mod]) begin
            res_r.module_current <= mn_r;
            res_r.module_peak    <= mh_r;
            res_r.module_allocs  <= mc_r;
          end else begin
            res_r.module_current <= '0;
            res_r.module_peak    <= '0;
            res_r.module_allocs  <= '0;
          end
          ovalid_r <= 1'b1;
          state_r  <= S_IDLE;
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end
endmodule

/* rtl/allocation_tracking_monitor.sv */
// ----------------------------------------------------------------------------
// allocation_tracking_monitor
// tracks allocate and free events and reports usage statistics
// ----------------------------------------------------------------------------
// channel | dir | contents
// in_     | in  | op, address, size, callsite, module_id, read_index
// out_    | out | global counters, histogram, site and module entries
// cfg_    | in  | enable bit
// a read goes through S_RD and S_OUT; an allocate first searches the site
// table slot by slot; a free scans the records one by one and then moves each
// later record down, since the record memory gives one registered read a cycle.
// reset clears counters and valid bits; record memory needs no clearing.
// a two-entry command queue lets input run ahead while results stall.
// ----------------------------------------------------------------------------
module allocation_tracking_monitor (
  input  logic clk,
  input  logic rst_n,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic        cfg_enable,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [1:0]  in_op,
  input  logic [47:0] in_address,
  input  logic [31:0] in_size,
  input  logic [47:0] in_callsite,
  input  logic [5:0]  in_module_id,
  input  logic [6:0]  in_read_index,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [10:0] out_live_records,
  output logic [47:0] out_current_bytes,
  output logic [47:0] out_byte_peak,
  output logic [47:0] out_byte_sum,
  output logic [31:0] out_total_count,
  output logic [31:0] out_hist_count,
  output logic [47:0] out_site_address,
  output logic [31:0] out_site_allocs,
  output logic [47:0] out_site_bytes,
  output logic [47:0] out_module_current,
  output logic [47:0] out_module_peak,
  output logic [31:0] out_module_allocs
);
  import atm_pkg::*;

  logic    enable_r;
  logic    q_valid, q_pop;
  work_t   q_data;
  result_t res;

  assign cfg_ready = 1'b1;

  // enable register
  always_ff @(posedge clk) begin
    if (!rst_n) enable_r <= 1'b0;
    else if (cfg_valid) enable_r <= cfg_enable;
  end

  atm_front u_front (
    .clk, .rst_n, .enable(enable_r), .in_valid, .in_ready,
    .op(in_op), .address(in_address), .size(in_size), .callsite(in_callsite),
    .module_id(in_module_id), .read_index(in_read_index),
    .q_valid, .q_pop, .q_data
  );

  atm_back u_back (
    .clk, .rst_n, .q_valid, .q_pop, .q_data,
    .out_valid, .out_ready, .out_data(res)
  );

  assign out_live_records   = res.live_records;
  assign out_current_bytes  = res.current_bytes;
  assign out_byte_peak      = res.byte_peak;
  assign out_byte_sum       = res.byte_sum;
  assign out_total_count    = res.total_count;
  assign out_hist_count     = res.hist_count;
  assign out_site_address   = res.site_address;
  assign out_site_allocs    = res.site_allocs;
  assign out_site_bytes     = res.site_bytes;
  assign out_module_current = res.module_current;
  assign out_module_peak    = res.module_peak;
  assign out_module_allocs  = res.module_allocs;
endmodule

/* rtl/atm_checker.sv */
// ----------------------------------------------------------------------------
// atm_checker
// port-level checks of the allocation tracking monitor
// ----------------------------------------------------------------------------
module atm_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        out_valid,
  input logic        out_ready,
  input logic [10:0] out_live_records,
  input logic [47:0] out_current_bytes,
  input logic [47:0] out_byte_peak
);
  // peak never below current
  a_peak: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_byte_peak >= out_current_bytes) else $error("peak below current");
  // record count bounded
  a_live: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_live_records <= 11'd1024) else $error("live records overflow");
  // stalled result holds
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_current_bytes))
    else $error("result changed while stalled");
  // no result straight after reset
  a_rst: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result after reset");
endmodule

bind allocation_tracking_monitor atm_checker u_atm_checker (
  .clk, .rst_n, .out_valid, .out_ready, .out_live_records, .out_current_bytes,
  .out_byte_peak
);

/* dv/tb.sv */
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the allocation tracking monitor. Allocate, free and
// read transactions are driven in random bursts while the result side stalls
// on its own pattern. A scoreboard keeps its own copy of the record, site and
// module tables, predicts every report and compares it field by field.
// ----------------------------------------------------------------------------
module tb;
  timeunit 1ns;
  timeprecision 1ps;
  import atm_pkg::*;

  // live allocation held by the predictor
  typedef struct {
    logic [47:0] address;
    logic [31:0] size;
    logic [5:0]  module_id;
  } live_block_t;

  class usage_scoreboard;
    live_block_t live_blocks[$];
    logic [47:0] bytes_now, bytes_peak, bytes_total;
    logic [31:0] alloc_total;
    logic [31:0] bin_count[5];
    logic [47:0] site_key[SiteDepth];
    logic [31:0] site_allocs[SiteDepth];
    logic [47:0] site_bytes[SiteDepth];
    int          site_fill;
    logic [47:0] mod_now[ModCount];
    logic [47:0] mod_high[ModCount];
    logic [31:0] mod_allocs[ModCount];
    bit          enabled;
    result_t     expected_reports[$];
    int          errors;

    function void clear();
      live_blocks.delete();
      expected_reports.delete();
      bytes_now = '0; bytes_peak = '0; bytes_total = '0; alloc_total = '0;
      foreach (bin_count[i]) bin_count[i] = '0;
      foreach (site_key[i]) begin
        site_key[i] = '0; site_allocs[i] = '0; site_bytes[i] = '0;
      end
      foreach (mod_now[i]) begin
        mod_now[i] = '0; mod_high[i] = '0; mod_allocs[i] = '0;
      end
      site_fill = 0;
      enabled = 1'b0;
      errors = 0;
    endfunction

    function logic [47:0] add_bytes(logic [47:0] a, logic [47:0] b);
      logic [48:0] s;
      s = {1'b0, a} + {1'b0, b};
      return (s > {1'b0, ByteMax}) ? ByteMax : s[47:0];
    endfunction

    function logic [31:0] bump(logic [31:0] a);
      return (a == CntMax) ? CntMax : a + 32'd1;
    endfunction

    function int bucket_of(logic [31:0] s);
      if (s <= 32'd64) return 0;
      if (s <= 32'd256) return 1;
      if (s <= 32'd1024) return 2;
      if (s <= 32'd4096) return 3;
      return 4;
    endfunction

    function void track_alloc(work_t w);
      live_block_t blk;
      int slot;
      int b;
      if (live_blocks.size() < RecDepth) begin
        blk.address = w.address; blk.size = w.size; blk.module_id = w.module_id;
        live_blocks.push_back(blk);
      end
      bytes_total = add_bytes(bytes_total, {16'd0, w.size});
      bytes_now = add_bytes(bytes_now, {16'd0, w.size});
      alloc_total = bump(alloc_total);
      if (bytes_now > bytes_peak) bytes_peak = bytes_now;
      b = bucket_of(w.size);
      bin_count[b] = bump(bin_count[b]);
      // sites are kept in first-seen order, new ones dropped once full
      slot = site_fill;
      for (int i = 0; i < site_fill; i++)
        if (site_key[i] == w.callsite) begin
          slot = i;
          break;
        end
      if (slot == site_fill && site_fill < SiteDepth) begin
        site_key[slot] = w.callsite;
        site_allocs[slot] = '0;
        site_bytes[slot] = '0;
        site_fill++;
      end
      if (slot < site_fill) begin
        site_allocs[slot] = bump(site_allocs[slot]);
        site_bytes[slot] = add_bytes(site_bytes[slot], {16'd0, w.size});
      end
      if (w.module_id < ModCount) begin
        mod_now[w.module_id] = add_bytes(mod_now[w.module_id], {16'd0, w.size});
        mod_allocs[w.module_id] = bump(mod_allocs[w.module_id]);
        if (mod_now[w.module_id] > mod_high[w.module_id])
          mod_high[w.module_id] = mod_now[w.module_id];
      end
    endfunction

    function void track_free(logic [47:0] address);
      logic [47:0] sz;
      logic [5:0]  m;
      // oldest matching record goes
      foreach (live_blocks[i])
        if (live_blocks[i].address == address) begin
          sz = {16'd0, live_blocks[i].size};
          m = live_blocks[i].module_id;
          bytes_now = (bytes_now >= sz) ? bytes_now - sz : '0;
          if (m < ModCount && mod_now[m] >= sz) mod_now[m] = mod_now[m] - sz;
          live_blocks.delete(i);
          return;
        end
    endfunction

    function void note_event(work_t w);
      result_t r;
      int ri;
      if (enabled && w.address != '0) begin
        if (w.cmd == CMD_ALLOC) track_alloc(w);
        else if (w.cmd == CMD_FREE) track_free(w.address);
      end
      ri = int'(w.read_index);
      r = '0;
      r.live_records = 11'(live_blocks.size());
      r.current_bytes = bytes_now;
      r.byte_peak = bytes_peak;
      r.byte_sum = bytes_total;
      r.total_count = alloc_total;
      if (ri < 5) r.hist_count = bin_count[ri];
      if (ri < site_fill) begin
        r.site_address = site_key[ri];
        r.site_allocs = site_allocs[ri];
        r.site_bytes = site_bytes[ri];
      end
      if (ri < ModCount) begin
        r.module_current = mod_now[ri];
        r.module_peak = mod_high[ri];
        r.module_allocs = mod_allocs[ri];
      end
      expected_reports.push_back(r);
    endfunction

    function void compare(string field, logic [63:0] exp, logic [63:0] act);
      if (exp !== act) begin
        $error("%s mismatch: expected %0h, actual %0h", field, exp, act);
        errors++;
      end
    endfunction

    function void check_report(result_t act);
      result_t exp;
      if (expected_reports.size() == 0) begin
        $error("report with no transaction outstanding");
        errors++;
        return;
      end
      exp = expected_reports.pop_front();
      compare("live_records", exp.live_records, act.live_records);
      compare("current_bytes", exp.current_bytes, act.current_bytes);
      compare("byte_peak", exp.byte_peak, act.byte_peak);
      compare("byte_sum", exp.byte_sum, act.byte_sum);
      compare("total_count", exp.total_count, act.total_count);
      compare("hist_count", exp.hist_count, act.hist_count);
      compare("site_address", exp.site_address, act.site_address);
      compare("site_allocs", exp.site_allocs, act.site_allocs);
      compare("site_bytes", exp.site_bytes, act.site_bytes);
      compare("module_current", exp.module_current, act.module_current);
      compare("module_peak", exp.module_peak, act.module_peak);
      compare("module_allocs", exp.module_allocs, act.module_allocs);
    endfunction
  endclass

  logic clk;
  logic rst_n;

  atm_if #(.payload_t(work_t))   in_ch ();
  atm_if #(.payload_t(result_t)) out_ch ();
  atm_if #(.payload_t(logic))    cfg_ch ();

  usage_scoreboard usage_sb;
  int              burst_left;
  logic [47:0]     issued_addrs[$];
  logic [47:0]     site_pool[16];
  logic [47:0]     fill_base;
  bit              hold_request;

  allocation_tracking_monitor dut (
    .clk                (clk),
    .rst_n              (rst_n),
    .cfg_valid          (cfg_ch.valid),
    .cfg_ready          (cfg_ch.ready),
    .cfg_enable         (cfg_ch.data),
    .in_valid           (in_ch.valid),
    .in_ready           (in_ch.ready),
    .in_op              (in_ch.data.cmd),
    .in_address         (in_ch.data.address),
    .in_size            (in_ch.data.size),
    .in_callsite        (in_ch.data.callsite),
    .in_module_id       (in_ch.data.module_id),
    .in_read_index      (in_ch.data.read_index),
    .out_valid          (out_ch.valid),
    .out_ready          (out_ch.ready),
    .out_live_records   (out_ch.data.live_records),
    .out_current_bytes  (out_ch.data.current_bytes),
    .out_byte_peak      (out_ch.data.byte_peak),
    .out_byte_sum       (out_ch.data.byte_sum),
    .out_total_count    (out_ch.data.total_count),
    .out_hist_count     (out_ch.data.hist_count),
    .out_site_address   (out_ch.data.site_address),
    .out_site_allocs    (out_ch.data.site_allocs),
    .out_site_bytes     (out_ch.data.site_bytes),
    .out_module_current (out_ch.data.module_current),
    .out_module_peak    (out_ch.data.module_peak),
    .out_module_allocs  (out_ch.data.module_allocs)
  );

  // clock
  initial clk = 1'b0;
  always #5 clk = ~clk;

  // watchdog
  initial begin
    #100ms;
    $display("[FAIL] regression broken");
    $finish;
  end

  // accepted transactions on both channels
  always @(posedge clk) begin
    if (rst_n && in_ch.valid && in_ch.ready) usage_sb.note_event(in_ch.data);
    if (rst_n && out_ch.valid && out_ch.ready) usage_sb.check_report(out_ch.data);
  end

  // result side stalls, with one long hold-off once heavy traffic runs
  initial begin
    int mode;
    int span;
    bit held;
    held = 1'b0;
    out_ch.ready = 1'b0;
    @(posedge rst_n);
    forever begin
      if (hold_request && !held) begin
        held = 1'b1;
        repeat (3000) @(posedge clk) out_ch.ready <= 1'b0;
      end
      mode = $urandom_range(0, 2);
      span = $urandom_range(20, 200);
      repeat (span) @(posedge clk) begin
        case (mode)
          0: out_ch.ready <= 1'b1;
          1: out_ch.ready <= $urandom_range(0, 1);
          default: out_ch.ready <= ($urandom_range(0, 3) == 0);
        endcase
      end
    end
  end

  task automatic send_event(work_t w);
    int gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 12);
      if (gap > 0) begin
        in_ch.valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = $urandom_range(1, 30);
    end
    in_ch.valid <= 1'b1;
    in_ch.data <= w;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    burst_left--;
  endtask

  // drop valid and wait for every report to come back
  task automatic drain();
    in_ch.valid <= 1'b0;
    burst_left = 0;
    @(posedge clk);
    while (usage_sb.expected_reports.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);
  endtask

  task automatic write_enable(logic value);
    drain();
    cfg_ch.valid <= 1'b1;
    cfg_ch.data <= value;
    @(posedge clk);
    while (!cfg_ch.ready) @(posedge clk);
    cfg_ch.valid <= 1'b0;
    usage_sb.enabled = value;
  endtask

  function automatic work_t make_event(cmd_t cmd, logic [47:0] address, logic [31:0] size,
                                       logic [47:0] callsite, logic [5:0] module_id,
                                       logic [6:0] read_index);
    work_t w;
    w.cmd = cmd; w.address = address; w.size = size;
    w.callsite = callsite; w.module_id = module_id; w.read_index = read_index;
    return w;
  endfunction

  function automatic logic [31:0] pick_size();
    logic [31:0] edges[12] = '{0, 1, 64, 65, 256, 257, 1024, 1025, 4096, 4097,
                               32'hFFFF_FFFF, 32'h8000_0000};
    case ($urandom_range(0, 3))
      0: return edges[$urandom_range(0, 11)];
      1: return $urandom();
      default: return $urandom_range(1, 8192);
    endcase
  endfunction

  function automatic logic [47:0] rand48();
    return {16'($urandom()), $urandom()};
  endfunction

  // one random transaction, mostly well-formed alloc/free pairs
  task automatic random_event();
    work_t w;
    int pick;
    int k;
    w = make_event(CMD_READ, rand48(), $urandom(), rand48(), 6'($urandom_range(0, 63)),
                   7'($urandom_range(0, 127)));
    if ($urandom_range(0, 1) == 0) w.read_index = 7'($urandom_range(0, 8));
    pick = $urandom_range(0, 99);
    if (pick < 45) begin
      w.cmd = CMD_ALLOC;
      if (issued_addrs.size() > 0 && $urandom_range(0, 9) == 0)
        w.address = issued_addrs[$urandom_range(0, issued_addrs.size() - 1)];
      if (w.address == '0) w.address = 48'h1;
      w.size = pick_size();
      if ($urandom_range(0, 3) != 0) w.callsite = site_pool[$urandom_range(0, 15)];
      issued_addrs.push_back(w.address);
    end else if (pick < 75 && issued_addrs.size() > 0) begin
      w.cmd = CMD_FREE;
      k = $urandom_range(0, issued_addrs.size() - 1);
      w.address = issued_addrs[k];
      issued_addrs.delete(k);
    end else if (pick < 82) begin
      w.cmd = CMD_FREE;
    end else if (pick < 88) begin
      w.cmd = ($urandom_range(0, 1) == 0) ? CMD_ALLOC : CMD_FREE;
      w.address = '0;
    end else if (pick < 94) begin
      w.cmd = cmd_t'(2'd3);
    end
    send_event(w);
  endtask

  initial begin
    work_t w;
    usage_sb = new();
    usage_sb.clear();
    burst_left = 0;
    hold_request = 1'b0;
    rst_n = 1'b0;
    in_ch.valid = 1'b0;
    in_ch.data = '0;
    cfg_ch.valid = 1'b0;
    cfg_ch.data = 1'b0;
    foreach (site_pool[i]) site_pool[i] = rand48();
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // out of reset the block is disabled: events leave no trace
    send_event(make_event(CMD_ALLOC, 48'h1000, 32'd100, 48'h77, 6'd1, 7'd0));
    send_event(make_event(CMD_READ, '0, '0, '0, '0, 7'd1));
    write_enable(1'b1);

    // directed: histogram edges, field extremes, null and unmatched frees
    send_event(make_event(CMD_ALLOC, 48'hFFFF_FFFF_FFFF, 32'd0, 48'hFFFF_FFFF_FFFF, 6'd0, 7'd0));
    send_event(make_event(CMD_ALLOC, 48'h10, 32'd64, '0, 6'd63, 7'd1));
    send_event(make_event(CMD_ALLOC, 48'h20, 32'd65, 48'h5, 6'd63, 7'd2));
    send_event(make_event(CMD_ALLOC, 48'h30, 32'd256, 48'h5, 6'd2, 7'd3));
    send_event(make_event(CMD_ALLOC, 48'h40, 32'd257, 48'h6, 6'd2, 7'd4));
    send_event(make_event(CMD_ALLOC, 48'h50, 32'd1024, 48'h6, 6'd3, 7'd5));
    send_event(make_event(CMD_ALLOC, 48'h60, 32'd1025, 48'h7, 6'd3, 7'd63));
    send_event(make_event(CMD_ALLOC, 48'h70, 32'd4096, 48'h7, 6'd4, 7'd64));
    send_event(make_event(CMD_ALLOC, 48'h80, 32'd4097, 48'h8, 6'd4, 7'd127));
    send_event(make_event(CMD_ALLOC, 48'h90, 32'hFFFF_FFFF, 48'h8, 6'd5, 7'd4));
    send_event(make_event(CMD_ALLOC, 48'h0, 32'd500, 48'h9, 6'd6, 7'd6));
    send_event(make_event(CMD_FREE, 48'h0, '0, '0, '0, 7'd0));
    send_event(make_event(CMD_FREE, 48'hDEAD, '0, '0, '0, 7'd0));
    // duplicate address: the older record is freed first
    send_event(make_event(CMD_ALLOC, 48'h10, 32'd7, 48'h9, 6'd1, 7'd1));
    send_event(make_event(CMD_FREE, 48'h10, '0, '0, '0, 7'd63));
    send_event(make_event(CMD_FREE, 48'h10, '0, '0, '0, 7'd1));
    send_event(make_event(CMD_FREE, 48'h90, '0, '0, '0, 7'd5));
    send_event(make_event(cmd_t'(2'd3), 48'h30, 32'd9, 48'h3, 6'd7, 7'd2));
    send_event(make_event(CMD_READ, 48'h40, 32'd9, 48'h3, 6'd7, 7'd3));
    issued_addrs.delete();
    issued_addrs = '{48'hFFFF_FFFF_FFFF, 48'h20, 48'h30, 48'h40, 48'h50,
                     48'h60, 48'h70, 48'h80};

    // disabled phase
    write_enable(1'b0);
    repeat (30) random_event();
    write_enable(1'b1);

    // random traffic, enable toggled once midway
    repeat (210) random_event();
    write_enable(1'b0);
    repeat (20) random_event();
    write_enable(1'b1);
    // result side holds off for a long stretch while input keeps coming
    hold_request = 1'b1;
    repeat (200) random_event();

    // fresh callsites push the site table past its depth
    fill_base = 48'h8000_0000_0000;
    for (int i = 0; i < 70; i++)
      send_event(make_event(CMD_ALLOC, fill_base + 48'(i), pick_size(), rand48(),
                            6'($urandom_range(0, 63)), 7'($urandom_range(0, 127))));
    send_event(make_event(CMD_FREE, fill_base + 48'd69, '0, '0, '0, 7'd0));
    send_event(make_event(CMD_FREE, fill_base, '0, '0, '0, 7'd1));
    send_event(make_event(CMD_ALLOC, 48'h1234, 32'd300, 48'h42, 6'd9, 7'd127));
    send_event(make_event(CMD_FREE, fill_base + 48'd1, '0, '0, '0, 7'd2));
    write_enable(1'b0);

    if (usage_sb.errors == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule

/* allocation_tracking_monitor.f */
rtl/atm_pkg.sv
rtl/atm_if.sv
rtl/atm_front.sv
rtl/atm_back.sv
rtl/allocation_tracking_monitor.sv
rtl/atm_checker.sv
dv/tb.sv
